>>> src/assert_macros.svh
// Assertion macros for the block's RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked while out of reset.
`define SSC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// Checked at every edge, reset included.
`define SSC_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");
`else
`define SSC_ASSERT(lbl, clk, rst_n, prop)
`define SSC_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> src/ssc_pkg.sv
package ssc_pkg;

  localparam int unsigned MAX_ADC_BITS     = 24;
  localparam int unsigned DEFAULT_ADC_BITS = 12;
  localparam int unsigned PERCENT_SCALE    = 10000;

  localparam int unsigned DIV_DW    = 24;               // divisor width
  localparam int unsigned DIV_STEPS = 20;               // quotient bits
  localparam int unsigned DIV_NW    = DIV_DW + DIV_STEPS;

  // P0, P1, P2, divider steps, output stage
  localparam int unsigned NSTG = DIV_STEPS + 4;

  typedef enum logic [2:0] {
    REG_ADC_BITS  = 3'd0,
    REG_REF_MV    = 3'd1,
    REG_RAW_FIRST = 3'd2,
    REG_LUX_FIRST = 3'd3,
    REG_RAW_SECOND = 3'd4,
    REG_LUX_SECOND = 3'd5,
    REG_TRIG_LOW  = 3'd6,
    REG_DIG_EN    = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [19:0] llo;
    logic        rising;
    logic        zero;
    logic        lvl;
    logic        trig;
    logic        dv;
  } side_t;

endpackage

>>> src/ssc_div_pipe.sv
module ssc_div_pipe import ssc_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic [DIV_NW-1:0]    num_i,
  input  logic [DIV_DW-1:0]    den_i,
  output logic [DIV_STEPS-1:0] quo_o
);

  // Restoring divider, one quotient bit per stage. Caller guarantees
  // quotient < 2^DIV_STEPS, so the top DIV_DW bits start below den.
  logic [DIV_NW-1:0] w_q [DIV_STEPS];
  logic [DIV_DW-1:0] d_q [DIV_STEPS];
  logic [DIV_NW-1:0] w_in [DIV_STEPS];
  logic [DIV_DW-1:0] d_in [DIV_STEPS];

  assign w_in[0] = num_i;
  assign d_in[0] = den_i;

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    logic [DIV_DW:0]   t;
    logic [DIV_DW:0]   diff;
    logic              ge;
    logic [DIV_DW-1:0] nrem;
    logic [DIV_NW-1:0] w_d;

    if (k > 0) begin : g_link
      assign w_in[k] = w_q[k-1];
      assign d_in[k] = d_q[k-1];
    end

    always_comb begin
      t    = w_in[k][DIV_NW-1 -: (DIV_DW+1)];
      diff = t - {1'b0, d_in[k]};
      ge   = (t >= {1'b0, d_in[k]});
      nrem = ge ? diff[DIV_DW-1:0] : t[DIV_DW-1:0];
      w_d  = {nrem, w_in[k][DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        w_q[k] <= '0;
        d_q[k] <= '0;
      end else if (en_i) begin
        w_q[k] <= w_d;
        d_q[k] <= d_in[k];
      end
    end
  end

  assign quo_o = w_q[DIV_STEPS-1][DIV_STEPS-1:0];

endmodule

>>> src/sensor_sample_scaler_unit.sv
// sensor_sample_scaler_unit
// Scales one raw converter sample plus one digital pin level per item into
// millivolts, hundredths of a percent of full scale, interpolated lux and
// the digital trigger flags.
// Channels: input item (raw_sample_i, pin_level_i) on in_valid_i/in_stall_o,
// result item on out_valid_o/out_stall_i; an item moves at an edge with
// valid high and stall low. Configuration is a plain write port
// (cfg_we_i, cfg_idx_i, cfg_data_i); write only while the block is empty.
// Pipeline: 24 register stages (two prep stages, one multiply stage,
// 20 divider stages of one quotient bit each, one output stage).
// Throughput: one item per cycle while the receiver does not stall, set by the fully pipelined dividers.
// Reset clears all valid bits and loads the register defaults.
// Receiver stall: the whole pipeline freezes while the output item waits,
// and in_stall_o rises at once; nothing is dropped or repeated.
module sensor_sample_scaler_unit import ssc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [23:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [23:0] raw_sample_i,
  input  logic        pin_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] millivolts_o,
  output logic [19:0] lux_o,
  output logic [13:0] percent_hundredths_o,
  output logic        level_out_o,
  output logic        triggered_o,
  output logic        sense_valid_o
);

  // ---- configuration registers
  logic [4:0]  adc_bits_q;
  logic [15:0] ref_mv_q;
  logic [23:0] raw1_q, raw2_q;
  logic [19:0] lux1_q, lux2_q;
  logic        trig_low_q, dig_en_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      adc_bits_q <= 5'd12;
      ref_mv_q   <= 16'd3300;
      raw1_q     <= '0;
      lux1_q     <= '0;
      raw2_q     <= 24'd4095;
      lux2_q     <= 20'd1000;
      trig_low_q <= 1'b0;
      dig_en_q   <= 1'b0;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_ADC_BITS:   adc_bits_q <= cfg_data_i[4:0];
        REG_REF_MV:     ref_mv_q   <= cfg_data_i[15:0];
        REG_RAW_FIRST:  raw1_q     <= cfg_data_i;
        REG_LUX_FIRST:  lux1_q     <= cfg_data_i[19:0];
        REG_RAW_SECOND: raw2_q     <= cfg_data_i;
        REG_LUX_SECOND: lux2_q     <= cfg_data_i[19:0];
        REG_TRIG_LOW:   trig_low_q <= cfg_data_i[0];
        REG_DIG_EN:     dig_en_q   <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // ---- pipeline control: global advance, valid bit per stage
  logic            en;
  logic [NSTG-1:0] v_q;

  assign en         = !v_q[NSTG-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[NSTG-2:0], in_valid_i};
    end
  end

  // ---- P0: effective resolution, full scale, point ordering
  logic [4:0]  bits_eff;
  logic [24:0] fs_wide;
  logic        swap;
  logic [23:0] p0_raw_q, p0_fs_q, p0_rlo_q, p0_rhi_q;
  logic [19:0] p0_llo_q, p0_lhi_q;
  logic        p0_lvl_q, p0_trig_q, p0_dv_q;

  always_comb begin
    if (adc_bits_q == 5'd0) begin
      bits_eff = 5'(DEFAULT_ADC_BITS);
    end else if (adc_bits_q > 5'(MAX_ADC_BITS)) begin
      bits_eff = 5'(MAX_ADC_BITS);
    end else begin
      bits_eff = adc_bits_q;
    end
    fs_wide = (25'd1 << bits_eff) - 25'd1;
    swap    = (raw1_q > raw2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p0_raw_q  <= raw_sample_i;
      p0_fs_q   <= fs_wide[23:0];
      p0_rlo_q  <= swap ? raw2_q : raw1_q;
      p0_rhi_q  <= swap ? raw1_q : raw2_q;
      p0_llo_q  <= swap ? lux2_q : lux1_q;
      p0_lhi_q  <= swap ? lux1_q : lux2_q;
      p0_lvl_q  <= dig_en_q & pin_level_i;
      p0_trig_q <= dig_en_q & (trig_low_q ? !pin_level_i : pin_level_i);
      p0_dv_q   <= dig_en_q;
    end
  end

  // ---- P1: clamps and differences
  logic [23:0] rc;
  logic        rising;
  logic [23:0] p1_c_q, p1_fs_q, p1_off_q, p1_span_q;
  logic [19:0] p1_dl_q;
  side_t       side_q [1:NSTG-2];
  side_t       side_d;

  always_comb begin
    if (p0_raw_q < p0_rlo_q) begin
      rc = p0_rlo_q;
    end else if (p0_raw_q > p0_rhi_q) begin
      rc = p0_rhi_q;
    end else begin
      rc = p0_raw_q;
    end
    rising        = (p0_lhi_q >= p0_llo_q);
    side_d.llo    = p0_llo_q;
    side_d.rising = rising;
    side_d.zero   = (p0_rlo_q == p0_rhi_q);
    side_d.lvl    = p0_lvl_q;
    side_d.trig   = p0_trig_q;
    side_d.dv     = p0_dv_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_c_q    <= (p0_raw_q > p0_fs_q) ? p0_fs_q : p0_raw_q;
      p1_fs_q   <= p0_fs_q;
      p1_off_q  <= rc - p0_rlo_q;
      p1_span_q <= p0_rhi_q - p0_rlo_q;
      p1_dl_q   <= rising ? (p0_lhi_q - p0_llo_q) : (p0_llo_q - p0_lhi_q);
      side_q[1] <= side_d;
    end
  end

  for (genvar k = 2; k < NSTG-1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // ---- P2: products, with rounding offset on millivolts and percent
  logic [DIV_NW-1:0] p2_mvn_q, p2_pcn_q, p2_lxn_q;
  logic [DIV_DW-1:0] p2_fs_q, p2_span_q;
  logic [39:0]       mv_prod;
  logic [37:0]       pc_prod;
  logic [43:0]       lx_prod;

  always_comb begin
    mv_prod = 40'(p1_c_q) * 40'(ref_mv_q);
    pc_prod = 38'(p1_c_q) * 38'(PERCENT_SCALE);
    lx_prod = 44'(p1_off_q) * 44'(p1_dl_q);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p2_mvn_q  <= DIV_NW'(mv_prod) + DIV_NW'(p1_fs_q >> 1);
      p2_pcn_q  <= DIV_NW'(pc_prod) + DIV_NW'(p1_fs_q >> 1);
      p2_lxn_q  <= lx_prod;
      p2_fs_q   <= p1_fs_q;
      // coinciding points: any non-zero divisor, result forced to 0 later
      p2_span_q <= (p1_span_q == '0) ? DIV_DW'(1) : p1_span_q;
    end
  end

  // ---- divider stages
  logic [DIV_STEPS-1:0] mv_quo, pc_quo, lx_quo;

  ssc_div_pipe u_div_mv (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .num_i(p2_mvn_q), .den_i(p2_fs_q), .quo_o(mv_quo)
  );

  ssc_div_pipe u_div_pc (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .num_i(p2_pcn_q), .den_i(p2_fs_q), .quo_o(pc_quo)
  );

  ssc_div_pipe u_div_lx (
    .clk_i(clk_i), .rst_ni(rst_ni), .en_i(en),
    .num_i(p2_lxn_q), .den_i(p2_span_q), .quo_o(lx_quo)
  );

  // ---- output stage
  side_t sd;
  assign sd = side_q[NSTG-2];

  logic [15:0] mv_q;
  logic [19:0] lux_q;
  logic [13:0] pc_q;
  logic        lvl_q, trig_q, dv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      mv_q   <= mv_quo[15:0];
      pc_q   <= pc_quo[13:0];
      if (sd.zero) begin
        lux_q <= '0;
      end else if (sd.rising) begin
        lux_q <= sd.llo + lx_quo;
      end else begin
        lux_q <= sd.llo - lx_quo;
      end
      lvl_q  <= sd.lvl;
      trig_q <= sd.trig;
      dv_q   <= sd.dv;
    end
  end

  assign out_valid_o          = v_q[NSTG-1];
  assign millivolts_o         = mv_q;
  assign lux_o                = lux_q;
  assign percent_hundredths_o = pc_q;
  assign level_out_o          = lvl_q;
  assign triggered_o          = trig_q;
  assign sense_valid_o        = dv_q;

  // ---- assertions
`include "assert_macros.svh"

  `SSC_ASSERT(a_stall_src, clk_i, rst_ni, in_stall_o |-> (out_valid_o && out_stall_i))
  `SSC_ASSERT(a_pct_range, clk_i, rst_ni, out_valid_o |-> (percent_hundredths_o <= 14'd10000))
  `SSC_ASSERT(a_lux_zero, clk_i, rst_ni, (out_valid_o && (raw1_q == raw2_q)) |-> (lux_o == '0))
  `SSC_ASSERT(a_trig_dis, clk_i, rst_ni, (out_valid_o && !sense_valid_o) |-> !(triggered_o || level_out_o))
  `SSC_ASSERT_ALWAYS(a_rst_empty, clk_i, !rst_ni |-> !out_valid_o)

endmodule

>>> test/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for sensor_sample_scaler_unit.
// Scoreboard class holds the predicted scaled items in order; plain tasks drive
// the write port, the input channel and the output stall.
class scaled_item_board;
  logic [15:0] mv_q[$];
  logic [19:0] lux_q[$];
  logic [13:0] pct_q[$];
  logic [2:0]  dig_q[$];   // {level, triggered, sense_valid}
  int          errors;

  function void note_input(logic [15:0] mv, logic [19:0] lux, logic [13:0] pct,
                           logic [2:0] dig);
    mv_q.push_back(mv);
    lux_q.push_back(lux);
    pct_q.push_back(pct);
    dig_q.push_back(dig);
  endfunction

  task report(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    errors++;
  endtask

  task check_result(logic [15:0] mv, logic [19:0] lux, logic [13:0] pct,
                    logic [2:0] dig);
    if (mv_q.size() == 0) begin
      report("unexpected item", 1, 0);
      return;
    end
    if (mv !== mv_q[0]) report("millivolts", mv, mv_q[0]);
    if (lux !== lux_q[0]) report("lux", lux, lux_q[0]);
    if (pct !== pct_q[0]) report("percent", pct, pct_q[0]);
    if (dig !== dig_q[0]) report("digital", dig, dig_q[0]);
    void'(mv_q.pop_front());
    void'(lux_q.pop_front());
    void'(pct_q.pop_front());
    void'(dig_q.pop_front());
  endtask

  function int pending();
    return mv_q.size();
  endfunction
endclass

module testbench;
  import ssc_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = REG_ADC_BITS;
  logic [23:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [23:0] raw_sample_i = '0;
  logic        pin_level_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] millivolts_o;
  logic [19:0] lux_o;
  logic [13:0] percent_hundredths_o;
  logic        level_out_o, triggered_o, sense_valid_o;

  // idle rates in percent for the sender and the receiver
  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;

  scaled_item_board board = new();

  // shadow copy of the register file
  logic [4:0]  sh_bits = 5'd12;
  logic [15:0] sh_ref = 16'd3300;
  logic [23:0] sh_raw1 = 24'd0;
  logic [19:0] sh_lux1 = 20'd0;
  logic [23:0] sh_raw2 = 24'd4095;
  logic [19:0] sh_lux2 = 20'd1000;
  logic        sh_low = 1'b0;
  logic        sh_en = 1'b0;

  always #5 clk_i = ~clk_i;

  sensor_sample_scaler_unit dut (.*);

  // interpolated lux, truncated; zero when the raw points coincide
  function automatic logic [19:0] interp_lux(logic [23:0] raw);
    logic [23:0] rlo, rhi, r;
    logic [19:0] llo, lhi;
    logic [63:0] q;
    if (sh_raw1 == sh_raw2) return '0;
    if (sh_raw1 < sh_raw2) begin
      rlo = sh_raw1; rhi = sh_raw2; llo = sh_lux1; lhi = sh_lux2;
    end else begin
      rlo = sh_raw2; rhi = sh_raw1; llo = sh_lux2; lhi = sh_lux1;
    end
    r = raw < rlo ? rlo : (raw > rhi ? rhi : raw);
    if (lhi >= llo) begin
      q = (64'(r - rlo) * 64'(lhi - llo)) / 64'(rhi - rlo);
      return llo + q[19:0];
    end
    q = (64'(r - rlo) * 64'(llo - lhi)) / 64'(rhi - rlo);
    return llo - q[19:0];
  endfunction

  // full expected item for one sample under the current shadow registers
  task automatic predict_scaled(input logic [23:0] raw, input logic pin);
    int unsigned b;
    logic [63:0] fs, c, mv, pct;
    logic lvl, trig;
    b = sh_bits;
    if (b == 0) b = DEFAULT_ADC_BITS;
    if (b > MAX_ADC_BITS) b = MAX_ADC_BITS;
    fs = (64'd1 << b) - 1;
    c = raw > fs ? fs : 64'(raw);
    mv = (c * sh_ref + fs / 2) / fs;
    pct = (c * PERCENT_SCALE + fs / 2) / fs;
    lvl = sh_en & pin;
    trig = sh_en & (sh_low ? !pin : pin);
    board.note_input(mv[15:0], interp_lux(raw), pct[13:0], {lvl, trig, sh_en});
  endtask

  // one write, then the enable is driven low again before the task returns
  task automatic write_reg(input reg_idx_e idx, input logic [23:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_ADC_BITS:   sh_bits = val[4:0];
      REG_REF_MV:     sh_ref  = val[15:0];
      REG_RAW_FIRST:  sh_raw1 = val;
      REG_LUX_FIRST:  sh_lux1 = val[19:0];
      REG_RAW_SECOND: sh_raw2 = val;
      REG_LUX_SECOND: sh_lux2 = val[19:0];
      REG_TRIG_LOW:   sh_low  = val[0];
      REG_DIG_EN:     sh_en   = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // one item; valid held until accepted, payload stable meanwhile
  task automatic send_sample(input logic [23:0] raw, input logic pin);
    while ($urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_sample_i <= raw;
    pin_level_i  <= pin;
    do @(posedge clk_i); while (in_stall_o);
    predict_scaled(raw, pin);
  endtask

  task automatic drain();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    // give the pipeline room before touching registers
    repeat (40) @(posedge clk_i);
  endtask

  // random sample biased towards the calibration window and full-scale edges
  function automatic logic [23:0] pick_raw();
    logic [23:0] lo, hi;
    lo = sh_raw1 < sh_raw2 ? sh_raw1 : sh_raw2;
    hi = sh_raw1 < sh_raw2 ? sh_raw2 : sh_raw1;
    case ($urandom_range(3))
      0: return 24'($urandom);
      1: return 24'($urandom_range(hi, lo));
      2: return 24'((32'd1 << $urandom_range(24)) - $urandom_range(1));
      default: return 24'($urandom_range(4095));
    endcase
  endfunction

  task automatic random_setting();
    write_reg(REG_ADC_BITS, 24'($urandom_range(31)));
    write_reg(REG_REF_MV, $urandom_range(3) == 0 ? 24'(0) : 24'($urandom));
    write_reg(REG_RAW_FIRST, $urandom_range(1) ? 24'($urandom) : 24'($urandom_range(4095)));
    write_reg(REG_LUX_FIRST, 24'($urandom));
    write_reg(REG_RAW_SECOND, $urandom_range(7) == 0 ? sh_raw1 : 24'($urandom));
    write_reg(REG_LUX_SECOND, $urandom_range(5) == 0 ? 24'(sh_lux1) : 24'($urandom));
    write_reg(REG_TRIG_LOW, 24'($urandom));
    write_reg(REG_DIG_EN, 24'($urandom));
  endtask

  // receiver side: stalls at the current rate, checks every accepted item
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        board.check_result(millivolts_o, lux_o, percent_hundredths_o,
                           {level_out_o, triggered_o, sense_valid_o});
      out_stall_i <= ($urandom_range(99) < recv_idle);
    end
  end

  initial begin
    #20ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst_ni <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset setting, extremes of the sample and pin
    send_sample(24'd0, 1'b0);
    send_sample(24'd4095, 1'b1);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'd2048, 1'b0);
    drain();
    // resolution zero falls back to 12, above 24 saturates; reference zero
    write_reg(REG_ADC_BITS, 24'd0);
    write_reg(REG_REF_MV, 24'd0);
    write_reg(REG_DIG_EN, 24'd1);
    send_sample(24'hFFFFFF, 1'b1);
    send_sample(24'd100, 1'b0);
    drain();
    write_reg(REG_ADC_BITS, 24'd31);
    write_reg(REG_REF_MV, 24'hFFFF);
    write_reg(REG_TRIG_LOW, 24'd1);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h800000, 1'b1);
    drain();
    // one-bit converter, rising slope with swapped points, max lux
    write_reg(REG_ADC_BITS, 24'd1);
    write_reg(REG_RAW_FIRST, 24'hFFFFFF);
    write_reg(REG_LUX_FIRST, 24'hFFFFF);
    write_reg(REG_RAW_SECOND, 24'd0);
    write_reg(REG_LUX_SECOND, 24'd0);
    send_sample(24'd0, 1'b0);
    send_sample(24'd1, 1'b1);
    send_sample(24'hFFFFFF, 1'b0);
    send_sample(24'h7FFFFF, 1'b1);
    drain();
    // coinciding raw points give zero lux; equal lux gives a constant
    write_reg(REG_RAW_SECOND, 24'hFFFFFF);
    send_sample(24'd5, 1'b1);
    drain();
    write_reg(REG_RAW_SECOND, 24'd10);
    write_reg(REG_LUX_SECOND, 24'hFFFFF);
    send_sample(24'd5, 1'b0);
    send_sample(24'd20, 1'b1);
    drain();

    // random phases: receiver-heavy idling, then sender-heavy, then none
    for (int ph = 0; ph < 3; ph++) begin
      send_idle = ph == 0 ? 22 : (ph == 1 ? 71 : 0);
      recv_idle = ph == 0 ? 71 : (ph == 1 ? 22 : 0);
      for (int s = 0; s < 5; s++) begin
        random_setting();
        for (int n = 0; n < 50; n++) send_sample(pick_raw(), 1'($urandom));
        drain();
      end
    end

    if (board.errors == 0 && board.pending() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end
endmodule

>>> sim.f
+incdir+src
src/ssc_pkg.sv
src/ssc_div_pipe.sv
src/sensor_sample_scaler_unit.sv
test/testbench.sv
